FILE: design/softmax_vector_core_assert.svh
// Assertion macros shared by the softmax vector core.
// Each expects clk and rst_n in the scope of the use.
`ifndef SOFTMAX_VECTOR_CORE_ASSERT_SVH
`define SOFTMAX_VECTOR_CORE_ASSERT_SVH

// same-cycle implication
`define SMX_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smx assertion failed");

// next-cycle implication
`define SMX_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smx assertion failed");

`endif

FILE: design/smx_pkg.sv
package smx_pkg;

  localparam int SCORE_W   = 16;
  localparam int PROB_W    = 16;
  localparam int Q_W       = 63;   // holds 1.0 in Q62
  localparam int PROD_W    = 125;
  localparam int DVD_W     = 64;
  localparam int EXP_BITS  = 16;
  localparam int BIT_W     = 4;
  localparam int SER_W     = 4;

  localparam logic [SER_W-1:0] SER_TERMS = 4'd12;
  localparam logic [BIT_W-1:0] SQ_LAST   = 4'd14;
  localparam logic [BIT_W-1:0] BIT_LAST  = 4'd15;

  localparam logic [Q_W-1:0] Q_ONE      = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [Q_W-1:0] ROUND_HALF = {{(Q_W-46){1'b0}}, 1'b1, {45{1'b0}}};
  localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic [PROB_W-1:0]  PROB_MAX  = {PROB_W{1'b1}};

  typedef enum logic [3:0] {
    S_SER_GO, S_SER_WAIT, S_SQ_GO, S_SQ_WAIT, S_IDLE, S_EXP_RD, S_EXP_D,
    S_BIT, S_BIT_WAIT, S_EXP_WR, S_DIV_RD, S_DIV_GO, S_DIV_WAIT, S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic ser_go;
    logic ser_upd;
    logic sq_go;
    logic sq_wr;
    logic load;
    logic exp_init;
    logic mul_acc_go;
    logic bit_step;
    logic acc_wr;
    logic exp_wr;
    logic idx_adv;
    logic idx_clr;
    logic div_go;
    logic out_load;
    logic vec_clr;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic ser_last;
    logic sq_last;
    logic bit_set;
    logic bit_last;
    logic elem_last;
    logic in_end;
  } stat_t;

endpackage

FILE: design/smx_if.sv
interface smx_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  score;
  logic                last;
  modport source (output valid, output score, output last, input ready);
  modport sink   (input valid, input score, input last, output ready);
endinterface

interface smx_out_if;
  logic         valid;
  logic         ready;
  logic [15:0]  probability;
  logic         last_out;
  modport source (output valid, output probability, output last_out, input ready);
  modport sink   (input valid, input probability, input last_out, output ready);
endinterface

FILE: design/softmax_vector_core.sv
// channel | dir | word                          | handshake
// in_s    | in  | score (s Q8.8), last          | valid/ready
// out_s   | out | probability (u Q0.16), last_out | valid/ready
//
// Scores load at one per cycle; the vector ends on last or at MAX_CLASSES scores.
// Exp walk: per score, a step over each of the 16 bits of (max - score), with
// one product per set bit on the shared multi-cycle 63x63 multiplier. Divide
// walk: each result comes from the one-bit-per-cycle divider, and out_s
// stalls hold it up. After reset an init pass builds the exp base table;
// in_s ready stays low until it ends. Reset is synchronous, active low.
module softmax_vector_core #(
  parameter int MAX_CLASSES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  smx_in_if.sink     in_s,
  smx_out_if.source  out_s
);
  import smx_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  smx_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_s.valid), .out_ready(out_s.ready),
    .stat(stat), .cmd(cmd), .in_ready(in_s.ready), .out_valid(out_s.valid)
  );

  smx_datapath #(.MAX_CLASSES(MAX_CLASSES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_score(in_s.score), .in_last(in_s.last),
    .out_probability(out_s.probability), .out_last_out(out_s.last_out)
  );

endmodule

FILE: design/smx_mul.sv
module smx_mul (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic [smx_pkg::Q_W-1:0] a,
  input  logic [smx_pkg::Q_W-1:0] b,
  output logic                    done,
  output logic [smx_pkg::Q_W-1:0] p
);
  import smx_pkg::*;

  logic [Q_W-1:0]    a_r, b_r;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [63:0]       prod_r;
  logic [31:0]       x, y;
  logic [2:0]        step_r;
  logic [1:0]        sh_r;
  logic              busy_r, done_r;
  logic [PROD_W-1:0] addend;

  // partial products: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    case (step_r)
      3'd0:    begin x = a_r[31:0];          y = b_r[31:0];          end
      3'd1:    begin x = a_r[31:0];          y = {1'b0, b_r[62:32]}; end
      3'd2:    begin x = {1'b0, a_r[62:32]}; y = b_r[31:0];          end
      default: begin x = {1'b0, a_r[62:32]}; y = {1'b0, b_r[62:32]}; end
    endcase
  end

  always_comb begin
    case (sh_r)
      2'd0:    addend = {{(PROD_W-64){1'b0}}, prod_r};
      2'd1:    addend = {{(PROD_W-64){1'b0}}, prod_r} << 32;
      default: addend = {{(PROD_W-64){1'b0}}, prod_r} << 64;
    endcase
    acc_nxt = acc_r + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r != 3'd4) begin
        prod_r <= x * y;
        sh_r   <= (step_r == 3'd0) ? 2'd0 : (step_r == 3'd3) ? 2'd2 : 2'd1;
      end
      if (step_r != 3'd0) acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign p    = acc_r[PROD_W-1:PROD_W-Q_W];

endmodule

FILE: design/smx_div.sv
module smx_div #(
  parameter int DVW = 22
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [smx_pkg::DVD_W-1:0] dividend,
  input  logic [DVW-1:0]            divisor,
  output logic                      done,
  output logic [smx_pkg::DVD_W-1:0] quotient
);
  import smx_pkg::*;

  logic [DVD_W-1:0] q_r;
  logic [DVW-1:0]   rem_r, div_r;
  logic [DVW:0]     sh, diff;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r, ge;

  always_comb begin
    sh   = {rem_r, q_r[DVD_W-1]};
    diff = sh - {1'b0, div_r};
    ge   = (sh >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVW-1:0] : sh[DVW-1:0];
      q_r   <= {q_r[DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: design/smx_ctrl.sv
module smx_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_ready,
  input  smx_pkg::stat_t stat,
  output smx_pkg::cmd_t  cmd,
  output logic           in_ready,
  output logic           out_valid
);
  import smx_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_SER_GO;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SER_GO:   state_nxt = S_SER_WAIT;
      S_SER_WAIT: if (stat.div_done) state_nxt = stat.ser_last ? S_SQ_GO : S_SER_GO;
      S_SQ_GO:    state_nxt = S_SQ_WAIT;
      S_SQ_WAIT:  if (stat.mul_done) state_nxt = stat.sq_last ? S_IDLE : S_SQ_GO;
      S_IDLE:     if (in_valid && stat.in_end) state_nxt = S_EXP_RD;
      S_EXP_RD:   state_nxt = S_EXP_D;
      S_EXP_D:    state_nxt = S_BIT;
      S_BIT: begin
        if (stat.bit_set)       state_nxt = S_BIT_WAIT;
        else if (stat.bit_last) state_nxt = S_EXP_WR;
      end
      S_BIT_WAIT: if (stat.mul_done) state_nxt = stat.bit_last ? S_EXP_WR : S_BIT;
      S_EXP_WR:   state_nxt = stat.elem_last ? S_DIV_RD : S_EXP_RD;
      S_DIV_RD:   state_nxt = S_DIV_GO;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (stat.div_done) state_nxt = S_OUT;
      S_OUT:      if (out_ready) state_nxt = stat.elem_last ? S_IDLE : S_DIV_RD;
      default:    state_nxt = S_SER_GO;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_SER_GO:   cmd.ser_go = 1'b1;
      S_SER_WAIT: cmd.ser_upd = stat.div_done;
      S_SQ_GO:    cmd.sq_go = 1'b1;
      S_SQ_WAIT:  cmd.sq_wr = stat.mul_done;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXP_RD:   ;
      S_EXP_D:    cmd.exp_init = 1'b1;
      S_BIT: begin
        cmd.mul_acc_go = stat.bit_set;
        cmd.bit_step   = !stat.bit_set;
      end
      S_BIT_WAIT: begin
        cmd.acc_wr   = stat.mul_done;
        cmd.bit_step = stat.mul_done;
      end
      S_EXP_WR: begin
        cmd.exp_wr  = 1'b1;
        cmd.idx_clr = stat.elem_last;
        cmd.idx_adv = !stat.elem_last;
      end
      S_DIV_RD:   ;
      S_DIV_GO:   cmd.div_go = 1'b1;
      S_DIV_WAIT: cmd.out_load = stat.div_done;
      S_OUT: begin
        out_valid   = 1'b1;
        cmd.vec_clr = out_ready && stat.elem_last;
        cmd.idx_adv = out_ready && !stat.elem_last;
      end
      default: ;
    endcase
  end

endmodule

FILE: design/smx_datapath.sv
module smx_datapath #(
  parameter int MAX_CLASSES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smx_pkg::cmd_t                       cmd,
  output smx_pkg::stat_t                      stat,
  input  logic signed [smx_pkg::SCORE_W-1:0]  in_score,
  input  logic                                in_last,
  output logic [smx_pkg::PROB_W-1:0]          out_probability,
  output logic                                out_last_out
);
  import smx_pkg::*;

  localparam int IW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CW    = $clog2(MAX_CLASSES + 1);
  localparam int TOT_W = SCORE_W + IW;

  logic [SCORE_W-1:0] score_mem [MAX_CLASSES];
  logic [PROB_W-1:0]  exp_mem   [MAX_CLASSES];
  logic [Q_W-1:0]     base_r    [EXP_BITS];

  logic signed [SCORE_W-1:0] max_r;
  logic [CW-1:0]      cnt_r;
  logic [IW-1:0]      idx_r;
  logic [TOT_W-1:0]   total_r;
  logic [SCORE_W-1:0] score_rd_r;
  logic [PROB_W-1:0]  exp_rd_r;
  logic [SCORE_W-1:0] d_r;
  logic [BIT_W-1:0]   bit_r;
  logic [SER_W-1:0]   ser_n_r;
  logic [Q_W-1:0]     term_r, sum_r, sum_nxt, acc_r, base_rd, rnd;
  logic [PROB_W-1:0]  exp_val, prob_r;
  logic               last_r;
  logic [SCORE_W:0]   diff;

  logic               mul_go, mul_done, div_go, div_done;
  logic [Q_W-1:0]     mul_a, mul_p;
  logic [DVD_W-1:0]   dvd, quo;
  logic [TOT_W-1:0]   dvs;

  assign base_rd = base_r[bit_r];
  assign sum_nxt = ser_n_r[0] ? sum_r - quo[Q_W-1:0] : sum_r + quo[Q_W-1:0];
  assign diff    = {max_r[SCORE_W-1], max_r} - {score_rd_r[SCORE_W-1], score_rd_r};
  assign rnd     = acc_r + ROUND_HALF;
  assign exp_val = rnd[Q_W-1] ? PROB_MAX : rnd[Q_W-2:46];

  assign mul_go = cmd.sq_go | cmd.mul_acc_go;
  assign mul_a  = cmd.mul_acc_go ? acc_r : base_rd;
  assign div_go = cmd.ser_go | cmd.div_go;
  assign dvd    = cmd.ser_go ? {9'd0, term_r[Q_W-1:8]}
                             : {{(DVD_W-2*PROB_W){1'b0}}, exp_rd_r, {PROB_W{1'b0}}};
  assign dvs    = cmd.ser_go ? TOT_W'(ser_n_r) : total_r;

  smx_mul u_mul (
    .clk(clk), .rst_n(rst_n), .go(mul_go), .a(mul_a), .b(base_rd),
    .done(mul_done), .p(mul_p)
  );

  smx_div #(.DVW(TOT_W)) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(dvd), .divisor(dvs),
    .done(div_done), .quotient(quo)
  );

  always_comb begin
    stat.div_done  = div_done;
    stat.mul_done  = mul_done;
    stat.ser_last  = (ser_n_r == SER_TERMS);
    stat.sq_last   = (bit_r == SQ_LAST);
    stat.bit_set   = d_r[bit_r];
    stat.bit_last  = (bit_r == BIT_LAST);
    stat.elem_last = ((CW'(idx_r) + CW'(1)) == cnt_r);
    stat.in_end    = in_last || (cnt_r == CW'(MAX_CLASSES - 1));
  end

  // control and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= SCORE_MIN;
      cnt_r   <= '0;
      idx_r   <= '0;
      total_r <= '0;
      bit_r   <= '0;
      ser_n_r <= SER_W'(1);
      term_r  <= Q_ONE;
      sum_r   <= Q_ONE;
    end else begin
      if (cmd.ser_upd) begin
        term_r  <= quo[Q_W-1:0];
        sum_r   <= sum_nxt;
        ser_n_r <= ser_n_r + SER_W'(1);
      end
      if (cmd.sq_wr || cmd.bit_step) bit_r <= bit_r + BIT_W'(1);
      if (cmd.exp_init) bit_r <= '0;
      if (cmd.load) begin
        cnt_r <= cnt_r + CW'(1);
        if (in_score > max_r) max_r <= in_score;
      end
      if (cmd.exp_wr) total_r <= total_r + TOT_W'(exp_val);
      if (cmd.idx_adv) idx_r <= idx_r + IW'(1);
      if (cmd.idx_clr) idx_r <= '0;
      if (cmd.vec_clr) begin
        max_r   <= SCORE_MIN;
        cnt_r   <= '0;
        idx_r   <= '0;
        total_r <= '0;
      end
    end
  end

  // payload registers and stores
  always_ff @(posedge clk) begin
    if (cmd.ser_upd)     base_r[0] <= sum_nxt;
    else if (cmd.sq_wr)  base_r[bit_r + BIT_W'(1)] <= mul_p;
    if (cmd.load)        score_mem[cnt_r[IW-1:0]] <= in_score;
    if (cmd.exp_wr)      exp_mem[idx_r] <= exp_val;
    score_rd_r <= score_mem[idx_r];
    exp_rd_r   <= exp_mem[idx_r];
    if (cmd.exp_init) begin
      d_r   <= diff[SCORE_W-1:0];
      acc_r <= Q_ONE;
    end else if (cmd.acc_wr) begin
      acc_r <= mul_p;
    end
    if (cmd.out_load) begin
      prob_r <= (|quo[DVD_W-1:PROB_W]) ? PROB_MAX : quo[PROB_W-1:0];
      last_r <= stat.elem_last;
    end
  end

  assign out_probability = prob_r;
  assign out_last_out    = last_r;

`include "softmax_vector_core_assert.svh"

  // the maximum score always contributes, so the divisor is never zero
  `SMX_ASSERT_IMP(a_total_nonzero, cmd.div_go, total_r != '0)
  `SMX_ASSERT_IMP(a_load_room, cmd.load, cnt_r < CW'(MAX_CLASSES))
  `SMX_ASSERT_NXT(a_vec_clear, cmd.vec_clr, cnt_r == '0 && total_r == '0 && idx_r == '0)
  `SMX_ASSERT_IMP(a_one_unit, mul_go, !div_go)

endmodule

FILE: test/softmax_vector_core_tb.sv
`timescale 1ns / 100ps

module softmax_vector_core_tb;
  import smx_pkg::*;

  localparam int VEC_MAX   = 64;
  localparam int QUIET_MAX = 60000;

  typedef struct {
    logic [PROB_W-1:0] probability;
    logic              last_out;
  } prob_word_t;

  // Q62 product, truncated
  function automatic logic [62:0] q62_mul(logic [62:0] a, logic [62:0] b);
    logic [125:0] p;
    p = {63'd0, a} * {63'd0, b};
    return p[124:62];
  endfunction

  function automatic logic [15:0] exp_neg_q16(logic [15:0] d);
    logic [63:0] sum;
    logic [63:0] term;
    logic [62:0] acc;
    logic [62:0] base;
    logic [63:0] r;
    sum  = 64'd1 << 62;
    term = 64'd1 << 62;
    for (int n = 1; n <= 12; n++) begin
      term = term / (64'd256 * n);
      if (n % 2) sum = sum - term;
      else sum = sum + term;
    end
    acc  = Q_ONE;
    base = sum[62:0];
    for (int b = 0; b < 16; b++) begin
      if (d[b]) acc = q62_mul(acc, base);
      base = q62_mul(base, base);
    end
    r = ({1'b0, acc} + (64'd1 << 45)) >> 46;
    return (r > 64'd65535) ? 16'hFFFF : r[15:0];
  endfunction

  class softmax_scoreboard;
    logic signed [15:0] scores[VEC_MAX];
    logic signed [15:0] peak;
    int                 fill;
    prob_word_t         probs_due[$];
    int                 mismatches;

    function void clear_vector();
      peak = SCORE_MIN;
      fill = 0;
    endfunction

    function void note_score(logic signed [15:0] s, logic is_last);
      logic [15:0] e[VEC_MAX];
      logic [21:0] total;
      logic [63:0] q;
      int          d;
      prob_word_t  w;
      if (fill >= VEC_MAX) fill = 0;
      scores[fill] = s;
      if (s > peak) peak = s;
      fill++;
      if (!is_last && fill < VEC_MAX) return;
      total = 0;
      for (int i = 0; i < fill; i++) begin
        d = int'(peak) - int'(scores[i]);
        e[i] = exp_neg_q16(d[15:0]);
        total = total + e[i];
      end
      for (int i = 0; i < fill; i++) begin
        q = ({48'd0, e[i]} << 16) / total;
        w.probability = (q > 64'd65535) ? PROB_MAX : q[15:0];
        w.last_out = (i == fill - 1);
        probs_due.push_back(w);
      end
      clear_vector();
    endfunction

    function void check_prob(logic [PROB_W-1:0] p, logic lst);
      prob_word_t w;
      if (probs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: prob=%0d last=%0b", p, lst);
        return;
      end
      w = probs_due.pop_front();
      if (w.probability !== p || w.last_out !== lst) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected prob=%0d last=%0b, got prob=%0d last=%0b",
                   w.probability, w.last_out, p, lst);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  smx_in_if  in_s();
  smx_out_if out_s();

  softmax_vector_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_s),
    .out_s (out_s)
  );

  softmax_scoreboard sb;
  int sender_idle;
  int recv_stall;
  int long_hold;
  int quiet;
  int sent;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_s.ready <= 1'b0;
    end else if (long_hold > 0) begin
      out_s.ready <= 1'b0;
      long_hold = long_hold - 1;
    end else begin
      out_s.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_s.valid && in_s.ready) sb.note_score(in_s.score, in_s.last);
      if (out_s.valid && out_s.ready) sb.check_prob(out_s.probability, out_s.last_out);
      if ((in_s.valid && in_s.ready) || (out_s.valid && out_s.ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_MAX) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic send_score(logic signed [15:0] s, logic is_last);
    if ($urandom_range(99) < sender_idle) begin
      in_s.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle) @(posedge clk);
    end
    in_s.valid <= 1'b1;
    in_s.score <= s;
    in_s.last  <= is_last;
    @(posedge clk);
    while (!in_s.ready) @(posedge clk);
    sent++;
  endtask

  // let the monitor note the final word before looking at the queue
  task automatic drain_all();
    in_s.valid <= 1'b0;
    @(posedge clk);
    while (sb.probs_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_score(int center, bit spread);
    int v;
    if (spread) return 16'($urandom_range(65535));
    v = center + int'($urandom_range(4000)) - 2000;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic send_vector(int len, bit mark_last, bit spread);
    int center;
    center = int'($signed(16'($urandom_range(65535))));
    for (int i = 0; i < len; i++)
      send_score(pick_score(center, spread), mark_last && (i == len - 1));
  endtask

  initial begin
    sb = new();
    sb.clear_vector();
    sb.mismatches = 0;
    sender_idle = 0;
    recv_stall = 0;
    long_hold = 0;
    quiet = 0;
    sent = 0;
    rst_n <= 1'b0;
    in_s.valid <= 1'b0;
    in_s.score <= '0;
    in_s.last  <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // single scores at both extremes, then mixed extremes, equal scores and mixed vectors
    send_score(16'sh7FFF, 1'b1);
    send_score(16'sh8000, 1'b1);
    send_score(16'sh8000, 1'b0);
    send_score(16'sh7FFF, 1'b1);
    send_score(16'sh0000, 1'b0);
    send_score(16'sh0000, 1'b0);
    send_score(16'sh0000, 1'b1);
    send_score(16'sh0100, 1'b0);
    send_score(16'sh0000, 1'b0);
    send_score(-16'sh0100, 1'b0);
    send_score(-16'sh0BC7, 1'b0);
    send_score(-16'sh0C00, 1'b0);
    send_score(16'shFFFF, 1'b1);
    send_score(16'sh5555, 1'b0);
    send_score(16'shAAAA, 1'b1);

    // hold the receiver off while scores keep coming
    long_hold = 3000;
    send_vector(8, 1'b1, 1'b0);
    send_vector(6, 1'b1, 1'b0);
    drain_all();

    // forced end at 64, then last on the 64th
    send_vector(VEC_MAX, 1'b0, 1'b0);
    send_vector(VEC_MAX, 1'b1, 1'b1);
    drain_all();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle = 0;  recv_stall = 0;  end
        1: begin sender_idle = 84; recv_stall = 0;  end
        2: begin sender_idle = 0;  recv_stall = 84; end
        default: begin sender_idle = 10; recv_stall = 10; end
      endcase
      while (sent < 170 + ph * 100) begin
        if ($urandom_range(19) == 0)
          send_vector(VEC_MAX, 1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          send_vector(int'($urandom_range(1, 10)), 1'b1, $urandom_range(3) == 0);
      end
    end

    drain_all();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.probs_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
